// ===== rtl/sorted_set_table_core_assert.svh =====
// Assertion macros shared by the sorted set table RTL.
`ifndef SORTED_SET_TABLE_CORE_ASSERT_SVH
`define SORTED_SET_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set table: next-cycle check failed");

`endif

// ===== rtl/sst_pkg.sv =====
// Package: widths, request and status codes, and the cell control word.
package sst_pkg;

    localparam int DATA_W       = 32;
    localparam int REQ_W        = 2;
    localparam int ST_W         = 2;
    localparam int POS_W        = 6;
    localparam int CNT_OUT_W    = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP     = 2'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic                     cmp_en;
        logic signed [DATA_W-1:0] cmp_key;
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] wr_key;
    } cell_ctl_t;

endpackage

// ===== rtl/sst_cell.sv =====
// One cell of the sorted row: holds a value and its compare flags.
module sst_cell
    import sst_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic                     occ,
    input  logic                     left_lt,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    output logic signed [DATA_W-1:0] val,
    output logic                     lt,
    output logic                     eq
);

    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                     lt_reg, lt_next;
    logic                     eq_reg, eq_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins && !lt_reg)
        begin
            // first cell not below the key takes it; the rest shift up
            val_next = left_lt ? ctl.wr_key : left_val;
        end
        else if (ctl.rem && !lt_reg)
        begin
            // close the gap: take the right neighbor
            val_next = right_val;
        end
    end

    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctl.cmp_en)
        begin
            lt_next = occ && (val_reg < ctl.cmp_key);
            eq_next = occ && (val_reg == ctl.cmp_key);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

// ===== rtl/sst_enc.sv =====
// Boundary encoder: turns the row's compare flags into an index and a hit.
module sst_enc
    import sst_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY)
)
(
    input  logic [CAPACITY-1:0] lt_vec,
    input  logic [CAPACITY-1:0] eq_vec,
    output logic [IDX_W-1:0]    idx,
    output logic                hit
);

    logic [CAPACITY-1:0] bound;

    // lt flags form a prefix; mark the first cell past it
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                bound[i] = !lt_vec[i];
            else
                bound[i] = !lt_vec[i] && lt_vec[i-1];
        end
    end

    // one-hot to binary: OR of the marked positions per index bit
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bound[i])
                idx = idx | IDX_W'(i);
        end
    end

    assign hit = |eq_vec;

endmodule

// ===== rtl/sorted_set_table_core.sv =====
// Top level: sorted set table built from a row of compare-and-shift cells.
// Flow: an accepted request word is held, compared into the cell flags in S_CMP, then
// encoded and shifted across the cell row in S_EXEC, where its result word is registered;
// the shift stalls while a result waits. A new request is taken only as the last one finishes.
// Reset: the fill count, the tolerant-remove register and all handshake state
// clear at once; cell contents stay undefined and are only read below the count.
module sorted_set_table_core
    import sst_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel: bit 0 = tolerate_missing_remove
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // request words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] position, [12:6] count, [15:13] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic                     tol_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] key_reg;
    logic [REQ_W-1:0]         req_reg;
    logic signed [DATA_W-1:0] exec_key_reg;
    logic [REQ_W-1:0]         exec_req_reg;

    logic                     m_valid_reg;
    logic [ST_W-1:0]          status_reg, status_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CNT_OUT_W-1:0]     cnt_out_reg, cnt_out_next;

    logic                     in_fire;
    logic                     exec_go;
    logic                     exec_fire;
    logic                     full;
    logic                     ins_do;
    logic                     rem_do;
    logic [IDX_W-1:0]         pos_sel;

    logic [CAPACITY-1:0]      lt_vec;
    logic [CAPACITY-1:0]      eq_vec;
    logic [CAPACITY-1:0]      occ_vec;
    logic signed [DATA_W-1:0] vals [CAPACITY];
    logic [IDX_W-1:0]         idx;
    logic                     hit;
    cell_ctl_t                ctl;

    logic [POS_W+IDX_W-1:0]     pos_wide;
    logic [CNT_OUT_W+CNT_W-1:0] cnt_wide;

    // ------------------------------------------------------------------
    // Handshake and sequencing
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    // finish the shift only when the result slot is free or draining
    assign exec_go   = !m_valid_reg || m_tready;
    assign exec_fire = (state_reg == S_EXEC) && exec_go;
    assign s_tready  = (state_reg == S_IDLE) || exec_fire;
    assign in_fire   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_CMP;
            end
            S_CMP:
                state_next = S_EXEC;
            S_EXEC:
            begin
                if (exec_fire)
                    state_next = in_fire ? S_CMP : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tol_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
        end
    end

    // hold the request; hand it to the execute stage after the compare
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg <= s_tdata;
            req_reg <= s_tuser;
        end
        if (state_reg == S_CMP)
        begin
            exec_key_reg <= key_reg;
            exec_req_reg <= req_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign ctl.cmp_en  = (state_reg == S_CMP);
    assign ctl.cmp_key = key_reg;
    assign ctl.ins     = ins_do;
    assign ctl.rem     = rem_do;
    assign ctl.wr_key  = exec_key_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                     left_lt;
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;

        assign occ_vec[g] = CNT_W'(g) < count_reg;

        if (g == 0)
        begin : g_first
            assign left_lt  = 1'b1;
            assign left_val = '0;
        end
        else
        begin : g_inner
            assign left_lt  = lt_vec[g-1];
            assign left_val = vals[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_val = vals[g];
        end
        else
        begin : g_mid
            assign right_val = vals[g+1];
        end

        sst_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occ       (occ_vec[g]),
            .left_lt   (left_lt),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (vals[g]),
            .lt        (lt_vec[g]),
            .eq        (eq_vec[g])
        );
    end

    sst_enc #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_enc (
        .lt_vec (lt_vec),
        .eq_vec (eq_vec),
        .idx    (idx),
        .hit    (hit)
    );

    // ------------------------------------------------------------------
    // Execute: decide status, drive the shift, update the count
    // ------------------------------------------------------------------
    assign full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ins_do      = 1'b0;
        rem_do      = 1'b0;
        status_next = ST_OK;
        pos_sel     = '0;
        count_next  = count_reg;
        unique case (exec_req_reg)
            REQ_INSERT:
            begin
                // full check wins even over a duplicate
                if (full)
                    status_next = ST_FULL;
                else if (hit)
                    status_next = ST_DUP;
                else
                begin
                    ins_do     = exec_fire;
                    pos_sel    = idx;
                    count_next = exec_fire ? count_reg + 1'b1 : count_reg;
                end
            end
            REQ_REMOVE:
            begin
                if (hit)
                begin
                    rem_do     = exec_fire;
                    pos_sel    = idx;
                    count_next = exec_fire ? count_reg - 1'b1 : count_reg;
                end
                else
                    status_next = tol_reg ? ST_OK : ST_MISSING;
            end
            REQ_FIND:
            begin
                if (hit)
                    pos_sel = idx;
                else
                    status_next = ST_MISSING;
            end
            default:
            begin
                // unused request code: report ok and the current count
                status_next = ST_OK;
            end
        endcase
    end

    // truncate position and count to the result field widths
    assign pos_wide     = {{POS_W{1'b0}}, pos_sel};
    assign pos_next     = pos_wide[POS_W-1:0];
    assign cnt_wide     = {{CNT_OUT_W{1'b0}}, count_next};
    assign cnt_out_next = cnt_wide[CNT_OUT_W-1:0];

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (exec_fire)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, cnt_out_reg, pos_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "sorted_set_table_core_assert.svh"

    `SST_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SST_ASSERT_IMP(a_no_take_in_cmp, state_reg == S_CMP, !s_tready)
    `SST_ASSERT_NXT(a_insert_grows, exec_fire && ins_do, count_reg == $past(count_reg) + 1'b1)
    `SST_ASSERT_IMP(a_err_pos_zero, m_tvalid && m_tuser != ST_OK, m_tdata[5:0] == 6'd0)

endmodule
